// ----- sv/sfr_pkg.sv -----
`default_nettype none

package sfr_pkg;

	localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
	localparam logic [7:0]  SYNC_SECOND = 8'h5A;
	localparam logic [7:0]  TAIL_BYTE   = 8'hFF;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;

	// result buffer entries
	localparam int BUF_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_CRC_ERR = 2'd2,
		KIND_TAIL    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic [7:0] frame_cmd;
		logic [7:0] frame_len;
	} result_t;

	// CRC-16/MODBUS, one byte, LSB first
	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- sv/sfr_parser.sv -----
`default_nettype none

module sfr_parser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            byte_valid,
	input  wire logic [7:0]      rx_byte,
	output logic                 res_valid,
	output sfr_pkg::result_t     res
);

	typedef enum logic [2:0] {
		PH_HUNT     = 3'd0,
		PH_SYNC2    = 3'd1,
		PH_LEN      = 3'd2,
		PH_CMD      = 3'd3,
		PH_PAYLOAD  = 3'd4,
		PH_CRC_HI   = 3'd5,
		PH_CRC_LO   = 3'd6,
		PH_TAIL     = 3'd7
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_hi_q, crc_hi_d;
	logic [15:0] crc_upd;
	logic [15:0] crc_restart;
	logic [7:0]  cnt_inc;
	logic        is_sync1;

	assign crc_upd     = sfr_pkg::crc_add(crc_q, rx_byte);
	assign crc_restart = sfr_pkg::crc_add(sfr_pkg::CRC_INIT, sfr_pkg::SYNC_FIRST);
	assign cnt_inc     = cnt_q + 8'd1;
	assign is_sync1    = (rx_byte == sfr_pkg::SYNC_FIRST);

	always_comb begin
		phase_d          = phase_q;
		len_d            = len_q;
		cmd_d            = cmd_q;
		cnt_d            = cnt_q;
		crc_d            = crc_q;
		crc_hi_d         = crc_hi_q;
		res_valid        = 1'b0;
		res.kind         = sfr_pkg::KIND_PAYLOAD;
		res.payload_byte = 8'h00;
		res.frame_cmd    = cmd_q;
		res.frame_len    = len_q;
		case (phase_q)
			PH_HUNT: begin
				if (is_sync1) begin
					phase_d = PH_SYNC2;
					crc_d   = crc_restart;
				end
			end
			PH_SYNC2: begin
				if (rx_byte == sfr_pkg::SYNC_SECOND) begin
					phase_d = PH_LEN;
					crc_d   = crc_upd;
				end else if (is_sync1) begin
					crc_d = crc_restart;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_LEN: begin
				len_d   = rx_byte;
				crc_d   = crc_upd;
				phase_d = PH_CMD;
			end
			PH_CMD: begin
				cmd_d   = rx_byte;
				crc_d   = crc_upd;
				cnt_d   = 8'd0;
				phase_d = (len_q == 8'd0) ? PH_CRC_HI : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				crc_d            = crc_upd;
				cnt_d            = cnt_inc;
				if (cnt_inc == len_q) begin
					phase_d = PH_CRC_HI;
				end
				res_valid        = 1'b1;
				res.payload_byte = rx_byte;
			end
			PH_CRC_HI: begin
				crc_hi_d = rx_byte;
				phase_d  = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				if ({crc_hi_q, rx_byte} == crc_q) begin
					phase_d = PH_TAIL;
				end else begin
					res_valid = 1'b1;
					res.kind  = sfr_pkg::KIND_CRC_ERR;
					if (is_sync1) begin
						phase_d = PH_SYNC2;
						crc_d   = crc_restart;
					end else begin
						phase_d = PH_HUNT;
					end
				end
			end
			PH_TAIL: begin
				res_valid = 1'b1;
				if (rx_byte == sfr_pkg::TAIL_BYTE) begin
					res.kind = sfr_pkg::KIND_GOOD;
					phase_d  = PH_HUNT;
				end else begin
					res.kind = sfr_pkg::KIND_TAIL;
					if (is_sync1) begin
						phase_d = PH_SYNC2;
						crc_d   = crc_restart;
					end else begin
						phase_d = PH_HUNT;
					end
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		if (!byte_valid) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			len_q    <= 8'd0;
			cmd_q    <= 8'd0;
			cnt_q    <= 8'd0;
			crc_q    <= sfr_pkg::CRC_INIT;
			crc_hi_q <= 8'd0;
		end else if (byte_valid) begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			cmd_q    <= cmd_d;
			cnt_q    <= cnt_d;
			crc_q    <= crc_d;
			crc_hi_q <= crc_hi_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/sfr_out_buf.sv -----
`default_nettype none

module sfr_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire sfr_pkg::result_t  push_data,
	output logic                   not_full,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output sfr_pkg::result_t       out_data
);

	sfr_pkg::result_t mem_q [sfr_pkg::BUF_DEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             pop;

	assign out_valid = (count_q != 2'd0);
	assign not_full  = (count_q != 2'(sfr_pkg::BUF_DEPTH));
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/sync_frame_receiver_crc16_top.sv -----
// A result is written into the result buffer when the byte that causes it is taken, then offered on m_axis.
// One byte per cycle unless the buffer is full; parser state and byte-wide CRC update on each byte.
// A two-entry result buffer keeps s_axis_tready high while one result waits downstream.
// Reset (arst_n low, asynchronous): hunting for A5, CRC FFFF, result buffer empty.
`default_nettype none

module sync_frame_receiver_crc16_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [7:0] payload_byte, [15:8] frame_cmd, [23:16] frame_len
	output logic [1:0]       m_axis_tuser    // [1:0] kind
);

	logic             accept;
	logic             res_valid;
	sfr_pkg::result_t res;
	sfr_pkg::result_t out_res;

	assign accept = s_axis_tvalid && s_axis_tready;

	sfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(accept),
		.rx_byte   (s_axis_tdata),
		.res_valid (res_valid),
		.res       (res)
	);

	sfr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.not_full  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	assign m_axis_tdata = {out_res.frame_len, out_res.frame_cmd, out_res.payload_byte};
	assign m_axis_tuser = out_res.kind;

endmodule

`default_nettype wire
